// ===== hw/rtl/eslt_pkg.sv =====
package eslt_pkg;

   // Defaults for the top-level parameters
   localparam int TABLE_SLOTS_DEFAULT = 16;
   localparam int GEN_BITS_DEFAULT    = 32;

   // Width of the generation carried by a handle and reported per slot
   localparam int HANDLE_GEN_BITS = 32;

   // Supported-backend mask after reset: cpu, gpu and htp
   localparam logic [2:0] SUPPORTED_RESET = 3'b111;

   typedef enum logic [2:0] {
      OP_BEGIN_LOAD = 3'd0,
      OP_PUBLISH    = 3'd1,
      OP_CANCEL     = 3'd2,
      OP_ACQUIRE    = 3'd3,
      OP_FINISH     = 3'd4,
      OP_LOOKUP     = 3'd5,
      OP_DESCRIBE   = 3'd6,
      OP_SNAPSHOT   = 3'd7
   } op_kind_type;

   typedef enum logic [3:0] {
      ST_OK              = 4'd0,
      ST_BAD_SLOT        = 4'd1,
      ST_LEASE_ACTIVE    = 4'd2,
      ST_GEN_EXHAUSTED   = 4'd3,
      ST_LAYOUT_MISMATCH = 4'd4,
      ST_RESIDENT        = 4'd5,
      ST_STALE           = 4'd6,
      ST_NOT_READY       = 4'd7,
      ST_NOT_FOUND       = 4'd8,
      ST_NOT_LOADING     = 4'd9,
      ST_NOT_COMPUTING   = 4'd10
   } status_type;

   typedef enum logic [1:0] {
      LS_EMPTY     = 2'd0,
      LS_LOADING   = 2'd1,
      LS_READY     = 2'd2,
      LS_COMPUTING = 2'd3
   } lease_type;

   typedef enum logic [1:0] {
      BE_NONE = 2'd0,
      BE_CPU  = 2'd1,
      BE_GPU  = 2'd2,
      BE_HTP  = 2'd3
   } backend_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_SCAN,
      SQ_READ,
      SQ_EXEC,
      SQ_RESP
   } seq_state_type;

   // Per-slot fields other than the generation; all zero is the reset entry
   typedef struct packed {
      lease_type   lease;
      logic        key_valid;
      logic [7:0]  layer;
      logic [9:0]  expert;
      logic [1:0]  backend;
      logic [1:0]  layout;
   } meta_type;

   // One decoded request transaction
   typedef struct packed {
      op_kind_type                kind;
      logic [3:0]                 slot;
      logic [7:0]                 layer;
      logic [9:0]                 expert;
      logic [1:0]                 backend;
      logic [1:0]                 layout;
      logic [HANDLE_GEN_BITS-1:0] hgen;
   } req_type;

   // Decision of the operation unit
   typedef struct packed {
      status_type status;
      logic       wr_en;
      meta_type   meta;
   } op_res_type;

   // Response payload, status in the lowest bits
   typedef struct packed {
      logic [1:0]                 layout;
      logic [1:0]                 backend;
      logic [9:0]                 expert;
      logic [7:0]                 layer;
      logic                       has_key;
      lease_type                  state;
      logic [HANDLE_GEN_BITS-1:0] gen;
      logic [3:0]                 found_slot;
      status_type                 status;
   } rsp_type;

endpackage

// ===== hw/rtl/expert_slot_lease_table.sv =====
// Expert slot lease table.
// Requests arrive on the req_ stream: req_tuser carries the operation kind,
// req_tdata the slot, key, backend, layout and handle generation. Every
// request transaction yields exactly one response transaction on rsp_,
// carrying a status code and the state of the slot addressed or found.
// csr_we writes the supported-backend mask from csr_wdata; write it only
// while no request is in flight.
// Requests run one at a time through a small sequencer around a single
// slot memory read port, one key comparator and one operation unit.
// Direct operations step through read, execute and respond states before
// the next acceptance. Lookup scans the slots one per cycle through the
// read port and key comparator, ending early on a hit. Publish scans the
// slots for a duplicate key first, ending early on a hit, then reads and
// executes.
// Reset empties every slot at once (per-slot valid bits) and restores the
// backend mask to all supported; no clearing pass is needed.
// A stalled response waits in the output register; the next request is
// still taken, and its response waits until the output register frees.
module expert_slot_lease_table #(
   parameter int TABLE_SLOTS = eslt_pkg::TABLE_SLOTS_DEFAULT,
   parameter int GEN_BITS    = eslt_pkg::GEN_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[2:0]
   input  logic [2:0]  req_tuser,
   // slot[3:0], key_layer[11:4], key_expert[21:12], backend[23:22],
   // layout[25:24], handle_generation[57:26], zero[63:58]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[3:0], found_slot[7:4], slot_generation[39:8], slot_state[41:40],
   // has_key_out[42], layer_out[50:43], expert_out[60:51],
   // backend_out[62:61], layout_out[64:63], zero[71:65]
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata
);
   import eslt_pkg::*;

   localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CMP_W    = (GEN_BITS > HANDLE_GEN_BITS) ? GEN_BITS : HANDLE_GEN_BITS;
   localparam int RSP_PAD  = 72 - $bits(rsp_type);

   seq_state_type       state_ff, state_in;
   req_type             req_ff, req_in, req_dec;
   logic [SLOT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic                scan_end_ff, scan_end_in;
   logic                rd_scan_ff, rd_scan_in;
   logic [SLOT_W-1:0]   rd_idx_ff;
   logic                dup_ff, dup_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [2:0]          sup_ff, sup_in;

   logic                accept;
   logic                bad_slot;
   logic                hit;
   logic                scan_done;
   logic                out_free;
   logic [SLOT_W-1:0]   mem_rd_addr;
   meta_type            rd_meta;
   logic [GEN_BITS-1:0] rd_gen;
   logic                mem_wr_en;
   op_res_type          op_res;
   logic [GEN_BITS-1:0] op_gen;

   function automatic logic [HANDLE_GEN_BITS-1:0] low_gen(input logic [GEN_BITS-1:0] g);
      logic [CMP_W-1:0] e;
      e = CMP_W'(g);
      return e[HANDLE_GEN_BITS-1:0];
   endfunction

   function automatic rsp_type build_rsp(input status_type st, input logic [3:0] slot,
                                         input logic [HANDLE_GEN_BITS-1:0] g,
                                         input meta_type m);
      rsp_type r;
      r.status     = st;
      r.found_slot = slot;
      r.gen        = g;
      r.state      = m.lease;
      r.has_key    = m.key_valid;
      r.layer      = m.layer;
      r.expert     = m.expert;
      r.backend    = m.backend;
      r.layout     = m.layout;
      return r;
   endfunction

   // Decode the request transaction
   assign req_dec.kind    = op_kind_type'(req_tuser);
   assign req_dec.slot    = req_tdata[3:0];
   assign req_dec.layer   = req_tdata[11:4];
   assign req_dec.expert  = req_tdata[21:12];
   assign req_dec.backend = req_tdata[23:22];
   assign req_dec.layout  = req_tdata[25:24];
   assign req_dec.hgen    = req_tdata[57:26];

   assign req_tready = (state_ff == SQ_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign bad_slot   = {5'd0, req_dec.slot} >= 9'(TABLE_SLOTS);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Key comparator on the scanned entry
   assign hit = rd_scan_ff && rd_meta.key_valid &&
                (rd_meta.layer == req_ff.layer) && (rd_meta.expert == req_ff.expert);
   assign scan_done = hit || scan_end_ff;

   // Slot memory and operation unit
   assign mem_rd_addr = (state_ff == SQ_SCAN) ? scan_idx_ff : SLOT_W'(req_ff.slot);
   assign mem_wr_en   = (state_ff == SQ_EXEC) && op_res.wr_en;

   eslt_slot_mem #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .GEN_BITS    (GEN_BITS),
      .SLOT_W      (SLOT_W)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mem_rd_addr),
      .rd_meta (rd_meta),
      .rd_gen  (rd_gen),
      .wr_en   (mem_wr_en),
      .wr_addr (SLOT_W'(req_ff.slot)),
      .wr_meta (op_res.meta),
      .wr_gen  (op_gen)
   );

   eslt_op_unit #(
      .GEN_BITS (GEN_BITS)
   ) u_op_unit (
      .req       (req_ff),
      .supported (sup_ff),
      .dup       (dup_ff),
      .meta      (rd_meta),
      .gen       (rd_gen),
      .res       (op_res),
      .new_gen   (op_gen)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (accept) begin
               if (req_dec.kind == OP_LOOKUP) begin
                  state_in = SQ_SCAN;
               end else if (bad_slot) begin
                  state_in = SQ_RESP;
               end else if (req_dec.kind == OP_PUBLISH) begin
                  state_in = SQ_SCAN;
               end else begin
                  state_in = SQ_READ;
               end
            end
         end
         SQ_SCAN: begin
            if (scan_done) begin
               state_in = (req_ff.kind == OP_LOOKUP) ? SQ_RESP : SQ_READ;
            end
         end
         SQ_READ: begin
            state_in = SQ_EXEC;
         end
         SQ_EXEC: begin
            state_in = SQ_RESP;
         end
         SQ_RESP: begin
            if (out_free) begin
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   // Datapath and output register control
   always_comb begin
      req_in       = req_ff;
      scan_idx_in  = scan_idx_ff;
      scan_end_in  = scan_end_ff;
      rd_scan_in   = 1'b0;
      dup_in       = dup_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      sup_in       = csr_we ? csr_wdata : sup_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (accept) begin
               req_in      = req_dec;
               scan_idx_in = '0;
               scan_end_in = 1'b0;
               dup_in      = 1'b0;
               res_in      = build_rsp(ST_BAD_SLOT, req_dec.slot, '0, '0);
            end
         end
         SQ_SCAN: begin
            if (scan_done) begin
               dup_in = hit;
               if (hit) begin
                  res_in = build_rsp(ST_OK, 4'(rd_idx_ff), low_gen(rd_gen), rd_meta);
               end else begin
                  res_in = build_rsp(ST_NOT_FOUND, '0, '0, '0);
               end
            end else begin
               // Issue the next slot read
               rd_scan_in  = 1'b1;
               scan_end_in = (scan_idx_ff == SLOT_W'(TABLE_SLOTS - 1));
               if (scan_idx_ff != SLOT_W'(TABLE_SLOTS - 1)) begin
                  scan_idx_in = scan_idx_ff + SLOT_W'(1);
               end
            end
         end
         SQ_EXEC: begin
            res_in = build_rsp(op_res.status, req_ff.slot, low_gen(op_gen), op_res.meta);
         end
         SQ_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_scan_ff   <= 1'b0;
         scan_end_ff  <= 1'b0;
         sup_ff       <= SUPPORTED_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_scan_ff   <= rd_scan_in;
         scan_end_ff  <= scan_end_in;
         sup_ff       <= sup_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= mem_rd_addr;
      dup_ff      <= dup_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_data_ff};

   // An accepted transaction leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != SQ_IDLE))
      else $error("request accepted without leaving idle");

   // The slot memory is written only while executing an operation
   a_write_exec: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == SQ_EXEC) && (req_ff.kind != OP_LOOKUP) &&
                    (req_ff.kind != OP_SNAPSHOT) && (req_ff.kind != OP_DESCRIBE))
      else $error("slot memory written outside an updating operation");

   // A granted acquire moves the slot to computing
   a_acquire_grant: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == SQ_EXEC) && (req_ff.kind == OP_ACQUIRE) && (op_res.status == ST_OK))
      |-> (op_res.meta.lease == LS_COMPUTING) && op_res.wr_en)
      else $error("acquire granted without entering computing");

   // A scan hit ends the scan in the next cycle
   a_scan_hit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == SQ_SCAN) && hit) |=> (state_ff != SQ_SCAN))
      else $error("scan continued after a key hit");

endmodule

// ===== hw/rtl/eslt_slot_mem.sv =====
module eslt_slot_mem #(
   parameter int TABLE_SLOTS = eslt_pkg::TABLE_SLOTS_DEFAULT,
   parameter int GEN_BITS    = eslt_pkg::GEN_BITS_DEFAULT,
   parameter int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [SLOT_W-1:0]       rd_addr,
   output eslt_pkg::meta_type      rd_meta,
   output logic [GEN_BITS-1:0]     rd_gen,
   input  logic                    wr_en,
   input  logic [SLOT_W-1:0]       wr_addr,
   input  eslt_pkg::meta_type      wr_meta,
   input  logic [GEN_BITS-1:0]     wr_gen
);
   import eslt_pkg::*;

   localparam int META_W = $bits(meta_type);
   localparam int WORD_W = GEN_BITS + META_W;

   logic [WORD_W-1:0]      slot_ram [TABLE_SLOTS];
   logic [WORD_W-1:0]      rd_data_ff;
   logic                   rd_vld_ff;
   logic [TABLE_SLOTS-1:0] vld_ff;
   logic [TABLE_SLOTS-1:0] vld_in;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ram[wr_addr] <= {wr_gen, wr_meta};
      end
   end

   // Read one entry per cycle, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_ram[rd_addr];
   end

   // Mark written entries; an unwritten entry reads as the reset entry
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_meta = rd_vld_ff ? meta_type'(rd_data_ff[META_W-1:0]) : '0;
   assign rd_gen  = rd_vld_ff ? rd_data_ff[WORD_W-1:META_W] : '0;

endmodule

// ===== hw/rtl/eslt_op_unit.sv =====
module eslt_op_unit #(
   parameter int GEN_BITS = eslt_pkg::GEN_BITS_DEFAULT
) (
   input  eslt_pkg::req_type       req,
   input  logic [2:0]              supported,
   input  logic                    dup,
   input  eslt_pkg::meta_type      meta,
   input  logic [GEN_BITS-1:0]     gen,
   output eslt_pkg::op_res_type    res,
   output logic [GEN_BITS-1:0]     new_gen
);
   import eslt_pkg::*;

   localparam int CMP_W = (GEN_BITS > HANDLE_GEN_BITS) ? GEN_BITS : HANDLE_GEN_BITS;

   logic [CMP_W-1:0] gen_ext;
   logic [CMP_W-1:0] hgen_ext;
   logic             stale;
   logic             active;
   logic             be_ok;

   // Compare generation against the handle at the wider width
   assign gen_ext  = CMP_W'(gen);
   assign hgen_ext = CMP_W'(req.hgen);
   assign stale    = !meta.key_valid || (gen_ext != hgen_ext);
   assign active   = (meta.lease == LS_LOADING) || (meta.lease == LS_COMPUTING);

   // Layout must match a supported backend
   assign be_ok = (req.layout == req.backend) &&
                  (((req.backend == BE_CPU) && supported[0]) ||
                   ((req.backend == BE_GPU) && supported[1]) ||
                   ((req.backend == BE_HTP) && supported[2]));

   // Decide status and updated entry
   always_comb begin
      res.status = ST_OK;
      res.wr_en  = 1'b0;
      res.meta   = meta;
      new_gen    = gen;
      case (req.kind)
         OP_BEGIN_LOAD: begin
            if (active) begin
               res.status = ST_LEASE_ACTIVE;
            end else if (&gen) begin
               res.status = ST_GEN_EXHAUSTED;
            end else begin
               res.wr_en          = 1'b1;
               res.meta.key_valid = 1'b0;
               res.meta.backend   = '0;
               res.meta.layout    = '0;
               res.meta.lease     = LS_LOADING;
               new_gen            = gen + GEN_BITS'(1);
            end
         end
         OP_PUBLISH: begin
            if (meta.lease != LS_LOADING) begin
               res.status = ST_NOT_LOADING;
            end else if (!be_ok) begin
               res.status = ST_LAYOUT_MISMATCH;
            end else if (dup) begin
               res.status = ST_RESIDENT;
            end else begin
               res.wr_en          = 1'b1;
               res.meta.layer     = req.layer;
               res.meta.expert    = req.expert;
               res.meta.backend   = req.backend;
               res.meta.layout    = req.layout;
               res.meta.key_valid = 1'b1;
               res.meta.lease     = LS_READY;
            end
         end
         OP_CANCEL: begin
            if (meta.lease != LS_LOADING) begin
               res.status = ST_NOT_LOADING;
            end else begin
               res.wr_en      = 1'b1;
               res.meta.lease = LS_EMPTY;
            end
         end
         OP_ACQUIRE: begin
            if (stale) begin
               res.status = ST_STALE;
            end else if (meta.lease != LS_READY) begin
               res.status = ST_NOT_READY;
            end else begin
               res.wr_en      = 1'b1;
               res.meta.lease = LS_COMPUTING;
            end
         end
         OP_FINISH: begin
            if (meta.lease != LS_COMPUTING) begin
               res.status = ST_NOT_COMPUTING;
            end else begin
               res.wr_en      = 1'b1;
               res.meta.lease = LS_READY;
            end
         end
         OP_DESCRIBE: begin
            if (stale) begin
               res.status = ST_STALE;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== dv/expert_slot_lease_table_tb.sv =====
`timescale 1ns / 1ps

module expert_slot_lease_table_tb;
   import eslt_pkg::*;

   localparam int NUM_SLOTS      = TABLE_SLOTS_DEFAULT;
   localparam int KEY_POOL_SIZE  = 24;
   localparam int PHASE_OPS      = 170;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   // One queued table operation; live means hgen is an offset from the
   // slot's generation as predicted when the transaction goes out
   typedef struct packed {
      bit      live;
      req_type req;
   } lease_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_wdata = '0;

   // Predicted table contents
   logic [2:0]  backend_mask;
   lease_type   lease_q   [NUM_SLOTS];
   logic [31:0] gen_q     [NUM_SLOTS];
   bit          keyed_q   [NUM_SLOTS];
   logic [7:0]  layer_q   [NUM_SLOTS];
   logic [9:0]  expert_q  [NUM_SLOTS];
   logic [1:0]  backend_q [NUM_SLOTS];
   logic [1:0]  layout_q  [NUM_SLOTS];

   lease_cmd_type pending_ops[$];
   rsp_type     expected_rsps[$];
   req_type     cur_req;
   int          queued_count;
   int          accepted_count;
   int          error_count;
   int          gap_left;
   int          rx_wait;
   int          hold_left;
   int          tx_idle_max;
   int          rx_idle_max;
   bit          hold_wanted;
   bit          hold_done;
   int          idle_cycles;
   lease_cmd_type next_cmd;
   rsp_type     got_rsp;
   rsp_type     want_rsp;

   logic [7:0]  pool_layer  [KEY_POOL_SIZE];
   logic [9:0]  pool_expert [KEY_POOL_SIZE];

   expert_slot_lease_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int find_resident(logic [7:0] ly, logic [9:0] ex);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (keyed_q[i] && layer_q[i] == ly && expert_q[i] == ex) return i;
      end
      return -1;
   endfunction

   // Apply one operation to the predicted table and return its response
   function automatic rsp_type apply_table_op(req_type r);
      rsp_type    o;
      status_type st;
      int         s;
      int         hit;
      o = '0;
      st = ST_OK;
      s = r.slot;
      if (r.kind == OP_LOOKUP) begin
         hit = find_resident(r.layer, r.expert);
         if (hit < 0) begin
            o.status = ST_NOT_FOUND;
            return o;
         end
         s = hit;
      end else begin
         case (r.kind)
            OP_BEGIN_LOAD: begin
               if (lease_q[s] == LS_LOADING || lease_q[s] == LS_COMPUTING) begin
                  st = ST_LEASE_ACTIVE;
               end else if (gen_q[s] == '1) begin
                  st = ST_GEN_EXHAUSTED;
               end else begin
                  keyed_q[s] = 1'b0;
                  backend_q[s] = '0;
                  layout_q[s] = '0;
                  gen_q[s] = gen_q[s] + 1;
                  lease_q[s] = LS_LOADING;
               end
            end
            OP_PUBLISH: begin
               if (lease_q[s] != LS_LOADING) begin
                  st = ST_NOT_LOADING;
               end else if (r.backend == BE_NONE || r.layout != r.backend) begin
                  st = ST_LAYOUT_MISMATCH;
               end else if (!backend_mask[r.backend - 1]) begin
                  st = ST_LAYOUT_MISMATCH;
               end else if (find_resident(r.layer, r.expert) >= 0) begin
                  st = ST_RESIDENT;
               end else begin
                  layer_q[s] = r.layer;
                  expert_q[s] = r.expert;
                  backend_q[s] = r.backend;
                  layout_q[s] = r.layout;
                  keyed_q[s] = 1'b1;
                  lease_q[s] = LS_READY;
               end
            end
            OP_CANCEL: begin
               if (lease_q[s] != LS_LOADING) st = ST_NOT_LOADING;
               else lease_q[s] = LS_EMPTY;
            end
            OP_ACQUIRE, OP_DESCRIBE: begin
               if (!keyed_q[s] || gen_q[s] != r.hgen) begin
                  st = ST_STALE;
               end else if (r.kind == OP_ACQUIRE) begin
                  if (lease_q[s] != LS_READY) st = ST_NOT_READY;
                  else lease_q[s] = LS_COMPUTING;
               end
            end
            OP_FINISH: begin
               if (lease_q[s] != LS_COMPUTING) st = ST_NOT_COMPUTING;
               else lease_q[s] = LS_READY;
            end
            default: ;
         endcase
      end
      o.status = st;
      o.found_slot = s[3:0];
      o.gen = gen_q[s];
      o.state = lease_q[s];
      o.has_key = keyed_q[s];
      o.layer = layer_q[s];
      o.expert = expert_q[s];
      o.backend = backend_q[s];
      o.layout = layout_q[s];
      return o;
   endfunction

   function automatic void add_op(op_kind_type k, int s, int ly, int ex, int be, int lo,
                                  logic [31:0] hg, bit live);
      lease_cmd_type c;
      c.live = live;
      c.req.kind = k;
      c.req.slot = s[3:0];
      c.req.layer = ly[7:0];
      c.req.expert = ex[9:0];
      c.req.backend = be[1:0];
      c.req.layout = lo[1:0];
      c.req.hgen = hg;
      pending_ops.insert(pending_ops.size(), c);
      queued_count++;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Wait until every queued transaction is answered, then let the block settle
   task automatic wait_drained();
      while (accepted_count != queued_count || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request driver: predict on acceptance, then present the next transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.insert(expected_rsps.size(), apply_table_op(cur_req));
            accepted_count++;
            gap_left = $urandom_range(0, tx_idle_max);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               next_cmd = pending_ops.pop_front();
               cur_req = next_cmd.req;
               if (next_cmd.live) cur_req.hgen = gen_q[cur_req.slot] + next_cmd.req.hgen;
               req_tvalid <= 1'b1;
               req_tuser <= cur_req.kind;
               req_tdata <= {6'b0, cur_req.hgen, cur_req.layout, cur_req.backend,
                             cur_req.expert, cur_req.layer, cur_req.slot};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check against the oldest prediction, then pace tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_type'(rsp_tdata[64:0]);
            if (expected_rsps.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               compare_field("status", want_rsp.status, got_rsp.status);
               compare_field("found_slot", want_rsp.found_slot, got_rsp.found_slot);
               compare_field("slot_generation", want_rsp.gen, got_rsp.gen);
               compare_field("slot_state", want_rsp.state, got_rsp.state);
               compare_field("has_key_out", want_rsp.has_key, got_rsp.has_key);
               compare_field("layer_out", want_rsp.layer, got_rsp.layer);
               compare_field("expert_out", want_rsp.expert, got_rsp.expert);
               compare_field("backend_out", want_rsp.backend, got_rsp.backend);
               compare_field("layout_out", want_rsp.layout, got_rsp.layout);
            end
            rx_wait = $urandom_range(0, rx_idle_max);
         end
         if (hold_wanted && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [2:0] phase_masks [5];
      int         added;
      int         s;
      int         k;
      int         be;
      int         r;

      queued_count = 0;
      accepted_count = 0;
      error_count = 0;
      tx_idle_max = 3;
      rx_idle_max = 3;
      hold_wanted = 1'b0;
      idle_cycles = 0;
      backend_mask = SUPPORTED_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         lease_q[i] = LS_EMPTY;
         gen_q[i] = '0;
         keyed_q[i] = 1'b0;
         layer_q[i] = '0;
         expert_q[i] = '0;
         backend_q[i] = '0;
         layout_q[i] = '0;
      end
      for (int i = 0; i < KEY_POOL_SIZE; i++) begin
         pool_layer[i] = $urandom_range(0, 255);
         pool_expert[i] = $urandom_range(0, 1023);
      end
      phase_masks[0] = 3'b000;
      phase_masks[1] = 3'b101;
      phase_masks[2] = 3'b010;
      phase_masks[3] = 3'b111;
      phase_masks[4] = $urandom_range(0, 7);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed pass with the reset backend mask. An exhausted generation
      // needs 2^32 - 1 loads of one slot, and a 4-bit slot never exceeds 15.
      add_op(OP_SNAPSHOT, 0, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_LOOKUP, 0, 255, 1023, 0, 0, 32'd0, 1'b0);
      add_op(OP_DESCRIBE, 3, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_ACQUIRE, 3, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_FINISH, 3, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_CANCEL, 3, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_PUBLISH, 3, 1, 1, BE_CPU, BE_CPU, 32'd0, 1'b0);
      add_op(OP_BEGIN_LOAD, 15, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_BEGIN_LOAD, 15, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_PUBLISH, 15, 255, 1023, BE_NONE, BE_NONE, 32'd0, 1'b0);
      add_op(OP_PUBLISH, 15, 255, 1023, BE_CPU, BE_GPU, 32'd0, 1'b0);
      add_op(OP_PUBLISH, 15, 255, 1023, BE_HTP, BE_HTP, 32'd0, 1'b0);
      add_op(OP_LOOKUP, 0, 255, 1023, 0, 0, 32'd0, 1'b0);
      add_op(OP_DESCRIBE, 15, 0, 0, 0, 0, 32'd0, 1'b1);
      add_op(OP_DESCRIBE, 15, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
      add_op(OP_ACQUIRE, 15, 0, 0, 0, 0, 32'd0, 1'b1);
      add_op(OP_ACQUIRE, 15, 0, 0, 0, 0, 32'd0, 1'b1);
      add_op(OP_BEGIN_LOAD, 15, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_FINISH, 15, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_BEGIN_LOAD, 0, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_PUBLISH, 0, 255, 1023, BE_CPU, BE_CPU, 32'd0, 1'b0);
      add_op(OP_CANCEL, 0, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_BEGIN_LOAD, 15, 0, 0, 0, 0, 32'd0, 1'b0);
      add_op(OP_LOOKUP, 0, 255, 1023, 0, 0, 32'd0, 1'b0);
      add_op(OP_PUBLISH, 15, 0, 0, BE_GPU, BE_GPU, 32'd0, 1'b0);

      // Random phases, each under its own backend mask
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         csr_we <= 1'b1;
         csr_wdata <= phase_masks[ph];
         backend_mask = phase_masks[ph];
         @(posedge clock);
         csr_we <= 1'b0;

         tx_idle_max = (ph == 2 || ph == 3) ? 0 : 3;
         rx_idle_max = (ph == 2) ? 0 : 3;
         if (ph == 3) hold_wanted = 1'b1;

         added = 0;
         while (added < PHASE_OPS) begin
            if ($urandom_range(0, 9) < 7) begin
               // Lease life cycle on one slot with random content
               s = $urandom_range(0, NUM_SLOTS - 1);
               k = $urandom_range(0, KEY_POOL_SIZE - 1);
               be = $urandom_range(1, 3);
               add_op(OP_BEGIN_LOAD, s, 0, 0, 0, 0, 32'd0, 1'b0);
               if ($urandom_range(0, 4) == 0) begin
                  add_op(OP_CANCEL, s, 0, 0, 0, 0, 32'd0, 1'b0);
                  added += 2;
               end else begin
                  add_op(OP_PUBLISH, s, pool_layer[k], pool_expert[k], be,
                         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : be,
                         32'd0, 1'b0);
                  r = $urandom_range(0, 5);
                  add_op(OP_ACQUIRE, s, 0, 0, 0, 0, (r == 0) ? 32'd1 : 32'd0, 1'b1);
                  add_op(OP_DESCRIBE, s, 0, 0, 0, 0,
                         ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : 32'd0, 1'b1);
                  if ($urandom_range(0, 3) != 0) begin
                     add_op(OP_FINISH, s, 0, 0, 0, 0, 32'd0, 1'b0);
                     added++;
                  end
                  add_op(OP_LOOKUP, 0, pool_layer[k], pool_expert[k], 0, 0, 32'd0, 1'b0);
                  add_op(OP_SNAPSHOT, s, 0, 0, 0, 0, 32'd0, 1'b0);
                  add_op(OP_CANCEL, s, 0, 0, 0, 0, 32'd0, 1'b0);
                  added += 7;
               end
            end else begin
               // Noise: any kind, any fields, arbitrary or near-live generation
               r = $urandom_range(0, 1);
               add_op(op_kind_type'($urandom_range(0, 7)), $urandom_range(0, NUM_SLOTS - 1),
                      $urandom_range(0, 255), $urandom_range(0, 1023),
                      $urandom_range(0, 3), $urandom_range(0, 3),
                      r ? 32'($urandom_range(0, 1)) : $urandom, r[0]);
               added++;
            end
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/eslt_pkg.sv
hw/rtl/eslt_slot_mem.sv
hw/rtl/eslt_op_unit.sv
hw/rtl/expert_slot_lease_table.sv
dv/expert_slot_lease_table_tb.sv
